### rtl/postnet_bar_codec_assert.svh
// ----------------------------------------------------------------------------
// postnet bar codec assertion macros
// concurrent checks clocked on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef POSTNET_BAR_CODEC_ASSERT_SVH
`define POSTNET_BAR_CODEC_ASSERT_SVH

// same-cycle implication
`define PBC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// types, constants and lookup functions of the postnet bar codec
// ----------------------------------------------------------------------------
package pbc_pkg;

	localparam int ZIP_W    = 17;
	localparam int BAR_W    = 27;
	localparam int DIGIT_W  = 4;
	localparam int GROUP_W  = 5;
	localparam int GROUPS   = 5;
	localparam int ERR_W    = 2;
	localparam int RECIP_W  = 29;
	localparam int PROD_W   = ZIP_W + RECIP_W;
	localparam int RECIP_SH = 32;

	localparam logic [ZIP_W-1:0] ZIP_MAX = 17'd99999;

	// ceil(2^32 / d), exact quotient for any 17-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_10    = 29'd429496730;
	localparam logic [RECIP_W-1:0] RECIP_100   = 29'd42949673;
	localparam logic [RECIP_W-1:0] RECIP_1000  = 29'd4294968;
	localparam logic [RECIP_W-1:0] RECIP_10000 = 29'd429497;

	localparam logic [ZIP_W-1:0] PLACE_VALUE [GROUPS] =
		'{17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1};

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FRAME = 2'd2;
	localparam logic [ERR_W-1:0] ERR_GROUP = 2'd3;

	typedef struct packed {
		logic             operation;
		logic [ZIP_W-1:0] zip_value;
		logic [BAR_W-1:0] bars_in;
	} pbc_in_t;

	typedef struct packed {
		logic [BAR_W-1:0] bars_out;
		logic [ZIP_W-1:0] zip_out;
		logic [ERR_W-1:0] error_code;
	} pbc_out_t;

	function automatic logic [GROUP_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
		logic [GROUP_W-1:0] c;
		case (d)
			4'd0:    c = 5'b11000;
			4'd1:    c = 5'b00011;
			4'd2:    c = 5'b00101;
			4'd3:    c = 5'b00110;
			4'd4:    c = 5'b01001;
			4'd5:    c = 5'b01010;
			4'd6:    c = 5'b01100;
			4'd7:    c = 5'b10001;
			4'd8:    c = 5'b10010;
			4'd9:    c = 5'b10100;
			default: c = 5'b00000;
		endcase
		return c;
	endfunction

	// weights 7,4,2,1,0 with a sum of 11 read as zero
	function automatic logic [DIGIT_W-1:0] code_digit(input logic [GROUP_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		case (c)
			5'b11000: d = 4'd0;
			5'b00011: d = 4'd1;
			5'b00101: d = 4'd2;
			5'b00110: d = 4'd3;
			5'b01001: d = 4'd4;
			5'b01010: d = 4'd5;
			5'b01100: d = 4'd6;
			5'b10001: d = 4'd7;
			5'b10010: d = 4'd8;
			5'b10100: d = 4'd9;
			default:  d = 4'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/pbc_encoder.sv
// ----------------------------------------------------------------------------
// pbc_encoder
// splits a binary zip code into five decimal digits and maps them to bars, flags values above 99999 as a range error
// ----------------------------------------------------------------------------
module pbc_encoder (
	input  logic [pbc_pkg::ZIP_W-1:0] zip_value,
	output pbc_pkg::pbc_out_t         result
);

	logic [pbc_pkg::PROD_W-1:0] prod1, prod2, prod3, prod4;
	logic [13:0] q1;
	logic [10:0] q2;
	logic [7:0]  q3;
	logic [3:0]  q4;
	logic [pbc_pkg::DIGIT_W-1:0] d0, d1, d2, d3, d4;
	logic [pbc_pkg::BAR_W-1:0] bars;

	// quotients by reciprocal multiplication
	assign prod1 = pbc_pkg::PROD_W'(zip_value) * pbc_pkg::PROD_W'(pbc_pkg::RECIP_10);
	assign prod2 = pbc_pkg::PROD_W'(zip_value) * pbc_pkg::PROD_W'(pbc_pkg::RECIP_100);
	assign prod3 = pbc_pkg::PROD_W'(zip_value) * pbc_pkg::PROD_W'(pbc_pkg::RECIP_1000);
	assign prod4 = pbc_pkg::PROD_W'(zip_value) * pbc_pkg::PROD_W'(pbc_pkg::RECIP_10000);

	assign q1 = prod1[pbc_pkg::RECIP_SH +: 14];
	assign q2 = prod2[pbc_pkg::RECIP_SH +: 11];
	assign q3 = prod3[pbc_pkg::RECIP_SH +: 8];
	assign q4 = prod4[pbc_pkg::RECIP_SH +: 4];

	// digit = quotient minus ten times the next quotient
	assign d0 = pbc_pkg::DIGIT_W'(zip_value - 17'(q1) * 17'd10);
	assign d1 = pbc_pkg::DIGIT_W'(q1 - 14'(q2) * 14'd10);
	assign d2 = pbc_pkg::DIGIT_W'(q2 - 11'(q3) * 11'd10);
	assign d3 = pbc_pkg::DIGIT_W'(q3 - 8'(q4) * 8'd10);
	assign d4 = q4;

	assign bars = {1'b1,
		pbc_pkg::digit_code(d4), pbc_pkg::digit_code(d3), pbc_pkg::digit_code(d2),
		pbc_pkg::digit_code(d1), pbc_pkg::digit_code(d0), 1'b1};

	always_comb begin
		result.zip_out = '0;
		if (zip_value > pbc_pkg::ZIP_MAX) begin
			result.bars_out   = '0;
			result.error_code = pbc_pkg::ERR_RANGE;
		end else begin
			result.bars_out   = bars;
			result.error_code = pbc_pkg::ERR_OK;
		end
	end

endmodule

### rtl/pbc_decoder.sv
// ----------------------------------------------------------------------------
// pbc_decoder
// checks frame bars and two-of-five groups, rebuilds the binary zip code
// ----------------------------------------------------------------------------
module pbc_decoder (
	input  logic [pbc_pkg::BAR_W-1:0] bars_in,
	output pbc_pkg::pbc_out_t         result
);

	logic [pbc_pkg::GROUP_W-1:0] grp [pbc_pkg::GROUPS];
	logic [pbc_pkg::GROUPS-1:0]  grp_ok;
	logic [pbc_pkg::ZIP_W-1:0]   zip;
	logic                        frame_ok;

	always_comb begin
		zip = '0;
		for (int g = 0; g < pbc_pkg::GROUPS; g++) begin
			grp[g]    = bars_in[(pbc_pkg::GROUPS - 1 - g) * pbc_pkg::GROUP_W + 1
				+: pbc_pkg::GROUP_W];
			grp_ok[g] = ($countones(grp[g]) == 2);
			zip       = zip + pbc_pkg::ZIP_W'(pbc_pkg::code_digit(grp[g]))
				* pbc_pkg::PLACE_VALUE[g];
		end
	end

	assign frame_ok = bars_in[pbc_pkg::BAR_W-1] & bars_in[0];

	always_comb begin
		result.bars_out = '0;
		if (!frame_ok) begin
			result.zip_out    = '0;
			result.error_code = pbc_pkg::ERR_FRAME;
		end else if (!(&grp_ok)) begin
			result.zip_out    = '0;
			result.error_code = pbc_pkg::ERR_GROUP;
		end else begin
			result.zip_out    = zip;
			result.error_code = pbc_pkg::ERR_OK;
		end
	end

endmodule

### rtl/postnet_bar_codec.sv
// An accepted item is held in the input register, then moves on to the result register, where result_valid marks it.
// Throughput: one item per cycle while result is not stalled, set by the input and result registers.
// item_stall rises only while both registers are full and result is stalled.
// Reset (arst_n low) clears both valid flags at once; payloads are not reset.
// ----------------------------------------------------------------------------
// postnet_bar_codec
// five-digit zip code to 27-bar postnet code and back, with error codes
// ----------------------------------------------------------------------------
`include "postnet_bar_codec_assert.svh"

module postnet_bar_codec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  pbc_pkg::pbc_in_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output pbc_pkg::pbc_out_t  result
);

	logic              s1_valid;
	pbc_pkg::pbc_in_t  item_s1;
	logic              s1_hold, s2_hold;
	pbc_pkg::pbc_out_t enc_res, dec_res, next_res;

	assign s2_hold    = result_valid & result_stall;
	assign s1_hold    = s1_valid & s2_hold;
	assign item_stall = s1_hold;

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!s1_hold) begin
			s1_valid <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_hold && item_valid) begin
			item_s1 <= item;
		end
	end

	pbc_encoder u_encoder (
		.zip_value (item_s1.zip_value),
		.result    (enc_res)
	);

	pbc_decoder u_decoder (
		.bars_in (item_s1.bars_in),
		.result  (dec_res)
	);

	assign next_res = (item_s1.operation == pbc_pkg::OP_ENCODE) ? enc_res : dec_res;

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!s2_hold) begin
			result_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!s2_hold && s1_valid) begin
			result <= next_res;
		end
	end

	`PBC_ASSERT_NOW(a_stall_full, item_stall, s1_valid && result_valid, "stall without full stages")
	`PBC_ASSERT_NEXT(a_accept_lands, item_valid && !item_stall, s1_valid, "accepted beat lost")
	`PBC_ASSERT_NOW(a_err_zero, result_valid && result.error_code != pbc_pkg::ERR_OK, result.bars_out == '0 && result.zip_out == '0, "error result not cleared")
	`PBC_ASSERT_NOW(a_frame_bars, result_valid && result.bars_out != '0, result.bars_out[pbc_pkg::BAR_W-1] && result.bars_out[0] && result.zip_out == '0, "encoded bars missing frame")

endmodule
